/* rtl/gdel_pkg.sv */
// shared types, constants and codes of the grouped dequantizing embedding lookup
package gdel_pkg;

	// default sizes of the tables
	localparam int MAX_ROWS_DEF   = 256;
	localparam int MAX_DIM_DEF    = 64;
	localparam int MAX_GROUPS_DEF = 8;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int ROW_W    = 8;
	localparam int COL_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int SCALE_W  = 32;
	localparam int VALUE_W  = 40;
	localparam int ELEM_W   = 6;
	localparam int CNT_W    = 4;
	localparam int LEN_W    = 7;
	localparam int DIFF_W   = BYTE_W + 2;

	// register port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register reset values
	localparam int GCOUNT_RST = 1;
	localparam int GLEN_RST   = 64;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WEIGHT = 2'd0,
		OP_SCALE  = 2'd1,
		OP_ZERO   = 2'd2,
		OP_LOOKUP = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_SIGNED = 2'd0,
		REG_USE_ZP = 2'd1,
		REG_GCOUNT = 2'd2,
		REG_GLEN   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic             signed_weights;
		logic             use_zero_points;
		logic [CNT_W-1:0] group_count;
		logic [LEN_W-1:0] group_length;
	} cfg_t;

	// element in flight between the table read and the output register
	typedef struct packed {
		logic              valid;
		logic [ELEM_W-1:0] elem_idx;
		logic              last;
	} meta_t;

endpackage

/* rtl/gdel_cmd_if.sv */
// command channel: table writes and row lookups
interface gdel_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [gdel_pkg::OPCODE_W-1:0]       opcode;
	logic [gdel_pkg::ROW_W-1:0]          row;
	logic [gdel_pkg::COL_W-1:0]          column;
	logic [gdel_pkg::BYTE_W-1:0]         byte_value;
	logic signed [gdel_pkg::SCALE_W-1:0] scale_value;

	modport source (output valid, opcode, row, column, byte_value, scale_value, input ready);
	modport sink (input valid, opcode, row, column, byte_value, scale_value, output ready);
endinterface

/* rtl/gdel_elem_if.sv */
// result channel: one dequantized element per word
interface gdel_elem_if;
	logic                                valid;
	logic                                ready;
	logic signed [gdel_pkg::VALUE_W-1:0] value;
	logic [gdel_pkg::ELEM_W-1:0]         element_index;
	logic                                last;

	modport source (output valid, value, element_index, last, input ready);
	modport sink (input valid, value, element_index, last, output ready);
endinterface

/* rtl/gdel_ram.sv */
// generic simple dual-port ram with registered read
module gdel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port, read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/gdel_cfg.sv */
// configuration registers behind the apb-style port
module gdel_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gdel_pkg::PADDR_W-1:0]   paddr,
	input  logic [gdel_pkg::PDATA_W-1:0]   pwdata,
	output logic [gdel_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output gdel_pkg::cfg_t                 cfg
);

	gdel_pkg::cfg_t     cfg_q;
	gdel_pkg::reg_idx_t idx;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = gdel_pkg::reg_idx_t'(paddr[gdel_pkg::PADDR_W-1:2]);
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signed_weights  <= 1'b0;
			cfg_q.use_zero_points <= 1'b0;
			cfg_q.group_count     <= gdel_pkg::CNT_W'(gdel_pkg::GCOUNT_RST);
			cfg_q.group_length    <= gdel_pkg::LEN_W'(gdel_pkg::GLEN_RST);
		end else if (wr) begin
			unique case (idx)
				gdel_pkg::REG_SIGNED: cfg_q.signed_weights  <= pwdata[0];
				gdel_pkg::REG_USE_ZP: cfg_q.use_zero_points <= pwdata[0];
				gdel_pkg::REG_GCOUNT: cfg_q.group_count     <= pwdata[gdel_pkg::CNT_W-1:0];
				gdel_pkg::REG_GLEN:   cfg_q.group_length    <= pwdata[gdel_pkg::LEN_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			gdel_pkg::REG_SIGNED: prdata = gdel_pkg::PDATA_W'(cfg_q.signed_weights);
			gdel_pkg::REG_USE_ZP: prdata = gdel_pkg::PDATA_W'(cfg_q.use_zero_points);
			gdel_pkg::REG_GCOUNT: prdata = gdel_pkg::PDATA_W'(cfg_q.group_count);
			gdel_pkg::REG_GLEN:   prdata = gdel_pkg::PDATA_W'(cfg_q.group_length);
		endcase
	end

endmodule

/* rtl/gdel_seq.sv */
// command decode, table write addressing and the element sequencer of a lookup
module gdel_seq #(
	parameter int MAX_ROWS   = gdel_pkg::MAX_ROWS_DEF,
	parameter int MAX_DIM    = gdel_pkg::MAX_DIM_DEF,
	parameter int MAX_GROUPS = gdel_pkg::MAX_GROUPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	gdel_cmd_if.sink                                cmd,
	input  gdel_pkg::cfg_t                          cfg,
	input  logic                                    advance,
	output gdel_pkg::meta_t                         meta_s1,
	output logic                                    w_we,
	output logic [$clog2(MAX_ROWS*MAX_DIM)-1:0]     w_waddr,
	output logic [$clog2(MAX_ROWS*MAX_DIM)-1:0]     w_raddr,
	output logic                                    s_we,
	output logic                                    z_we,
	output logic [$clog2(MAX_ROWS*MAX_GROUPS)-1:0]  g_waddr,
	output logic [$clog2(MAX_ROWS*MAX_GROUPS)-1:0]  g_raddr
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int WA    = $clog2(MAX_ROWS*MAX_DIM);
	localparam int SA    = $clog2(MAX_ROWS*MAX_GROUPS);
	localparam int LW    = gdel_pkg::LEN_W;
	localparam int TW    = 2 * gdel_pkg::LEN_W;
	localparam int EW    = gdel_pkg::ELEM_W;
	localparam int CW1   = gdel_pkg::COL_W + 1;
	localparam int NROWS = 1 << gdel_pkg::ROW_W;

	localparam logic [CW1-1:0] DIM_COL = CW1'(MAX_DIM);
	localparam logic [CW1-1:0] GRP_COL = CW1'(MAX_GROUPS);
	localparam logic [LW-1:0]  GRP_MAX = LW'(MAX_GROUPS);
	localparam logic [LW-1:0]  LEN_MAX = LW'(MAX_DIM);
	localparam logic [TW-1:0]  TOT_MAX = TW'(MAX_DIM);

	gdel_pkg::state_t  st_q, st_nxt;
	logic              ready, load, issue, accept;
	logic [RW-1:0]     row_lut [NROWS];
	logic [RW-1:0]     row_idx;
	logic [WA-1:0]     w_base;
	logic [SA-1:0]     g_base;
	logic              col_ok_w, col_ok_g;
	logic [LW-1:0]     gc_ext, groups_c, len_c;
	logic [TW-1:0]     prod_c, total_c;
	logic [EW-1:0]     last_c;
	logic [EW-1:0]     e_q, last_q;
	logic [LW-1:0]     gi_q, len_q;
	logic [WA-1:0]     wa_q;
	logic [SA-1:0]     ga_q;
	logic              e_last;

	// row wrap: constant table of row modulo the table height
	for (genvar i = 0; i < NROWS; i++) begin : g_row_lut
		assign row_lut[i] = RW'(i % MAX_ROWS);
	end

	assign row_idx = row_lut[cmd.row];
	assign w_base  = WA'(row_idx) * WA'(MAX_DIM);
	assign g_base  = SA'(row_idx) * SA'(MAX_GROUPS);

	// write addressing and range checks
	assign col_ok_w = {1'b0, cmd.column} < DIM_COL;
	assign col_ok_g = {1'b0, cmd.column} < GRP_COL;
	assign w_waddr  = w_base + WA'(cmd.column);
	assign g_waddr  = g_base + SA'(cmd.column);

	assign accept = cmd.valid && ready;
	assign w_we   = accept && (cmd.opcode == gdel_pkg::OP_WEIGHT) && col_ok_w;
	assign s_we   = accept && (cmd.opcode == gdel_pkg::OP_SCALE) && col_ok_g;
	assign z_we   = accept && (cmd.opcode == gdel_pkg::OP_ZERO) && col_ok_g;
	assign cmd.ready = ready;

	// clamp group count and length, then the emitted row length
	always_comb begin
		gc_ext = LW'(cfg.group_count);
		if (gc_ext == '0) begin
			groups_c = LW'(1);
		end else if (gc_ext > GRP_MAX) begin
			groups_c = GRP_MAX;
		end else begin
			groups_c = gc_ext;
		end
		if (cfg.group_length == '0) begin
			len_c = LW'(1);
		end else if (cfg.group_length > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = cfg.group_length;
		end
		prod_c  = TW'(groups_c) * TW'(len_c);
		total_c = (prod_c > TOT_MAX) ? TOT_MAX : prod_c;
		last_c  = EW'(total_c - TW'(1));
	end

	assign e_last = (e_q == last_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gdel_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// next state and sequencer controls
	always_comb begin
		st_nxt = st_q;
		ready  = 1'b0;
		load   = 1'b0;
		issue  = 1'b0;
		unique case (st_q)
			gdel_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (cmd.valid && (cmd.opcode == gdel_pkg::OP_LOOKUP)) begin
					load   = 1'b1;
					st_nxt = gdel_pkg::ST_RUN;
				end
			end
			gdel_pkg::ST_RUN: begin
				if (advance) begin
					issue = 1'b1;
					if (e_last) begin
						st_nxt = gdel_pkg::ST_IDLE;
					end
				end
			end
			default: st_nxt = gdel_pkg::ST_IDLE;
		endcase
	end

	// element, in-group and address counters
	always_ff @(posedge clk) begin
		if (load) begin
			e_q    <= '0;
			gi_q   <= '0;
			len_q  <= len_c;
			last_q <= last_c;
			wa_q   <= w_base;
			ga_q   <= g_base;
		end else if (issue) begin
			e_q  <= e_q + EW'(1);
			wa_q <= wa_q + WA'(1);
			if (gi_q == len_q - LW'(1)) begin
				gi_q <= '0;
				ga_q <= ga_q + SA'(1);
			end else begin
				gi_q <= gi_q + LW'(1);
			end
		end
	end

	assign w_raddr = wa_q;
	assign g_raddr = ga_q;

	// element tag that travels alongside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (advance) begin
			meta_s1.valid    <= issue;
			meta_s1.elem_idx <= e_q;
			meta_s1.last     <= e_last;
		end
	end

	// the final element of a row sends the sequencer back to idle
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		issue && e_last |=> st_q == gdel_pkg::ST_IDLE)
		else $error("sequencer kept running after the final element");

	// the element counter never passes the row end
	a_elem_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == gdel_pkg::ST_RUN |-> e_q <= last_q)
		else $error("element counter beyond row end");

	// a stalled element keeps its tag until the output stage takes it
	a_tag_holds: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s1.valid && !advance |=> meta_s1.valid && $stable(meta_s1.elem_idx))
		else $error("element tag lost during stall");

endmodule

/* rtl/gdel_dq.sv */
// dequantizer: byte interpretation, zero-point subtract, shared multiplier, output register
module gdel_dq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gdel_pkg::cfg_t                      cfg,
	input  gdel_pkg::meta_t                     meta_s1,
	input  logic [gdel_pkg::BYTE_W-1:0]         w_byte,
	input  logic [gdel_pkg::BYTE_W-1:0]         z_byte,
	input  logic [gdel_pkg::SCALE_W-1:0]        scale,
	output logic                                advance,
	gdel_elem_if.source                         elem
);

	localparam int DW = gdel_pkg::DIFF_W;
	localparam int PW = gdel_pkg::DIFF_W + gdel_pkg::SCALE_W;

	logic signed [DW-1:0]                  w_ext, z_ext, diff;
	logic signed [gdel_pkg::SCALE_W-1:0]   scale_s;
	logic signed [PW-1:0]                  prod;
	logic                                  valid_s2;
	logic [gdel_pkg::VALUE_W-1:0]          value_s2;
	logic [gdel_pkg::ELEM_W-1:0]           idx_s2;
	logic                                  last_s2;

	// bytes as unsigned or two's complement, zero point masked when unused
	always_comb begin
		if (cfg.signed_weights) begin
			w_ext = signed'({{(DW - gdel_pkg::BYTE_W){w_byte[gdel_pkg::BYTE_W-1]}}, w_byte});
			z_ext = signed'({{(DW - gdel_pkg::BYTE_W){z_byte[gdel_pkg::BYTE_W-1]}}, z_byte});
		end else begin
			w_ext = signed'(DW'(w_byte));
			z_ext = signed'(DW'(z_byte));
		end
		if (!cfg.use_zero_points) begin
			z_ext = '0;
		end
	end

	// difference times scale, exact
	assign diff    = w_ext - z_ext;
	assign scale_s = signed'(scale);
	assign prod    = PW'(diff) * PW'(scale_s);

	// output register; the pipeline moves when it is empty or being drained
	assign advance = !valid_s2 || elem.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= meta_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && meta_s1.valid) begin
			value_s2 <= prod[gdel_pkg::VALUE_W-1:0];
			idx_s2   <= meta_s1.elem_idx;
			last_s2  <= meta_s1.last;
		end
	end

	assign elem.valid         = valid_s2;
	assign elem.value         = signed'(value_s2);
	assign elem.element_index = idx_s2;
	assign elem.last          = last_s2;

endmodule

/* rtl/grouped_dequant_embedding_lookup_top.sv */
// top level of the grouped dequantizing embedding lookup
//
// Holds an 8-bit weight table (MAX_ROWS rows of MAX_DIM bytes) plus one Q15.16
// scale and one zero-point byte per row and group. A command word either writes
// one weight, scale or zero point (no result) or looks up a row. A lookup of
// N = min(group_count * group_length, MAX_DIM) elements streams N result words,
// one per cycle when the result side is not stalled, the last one flagged; the
// command side is busy from the lookup's acceptance until the last element is
// issued, and the first result passes the address counters, the table read
// registers and the output register. The element rate is set by the single read
// port of the weight memory and the one signed 10 x 32 multiplier, both used
// once per element. Rows wrap modulo MAX_ROWS, writes to columns or groups
// beyond the table are dropped, and out-of-range group settings are clamped.
// Table entries are undefined until written. Configuration registers at byte
// offsets 0x0 signed_weights, 0x4 use_zero_points, 0x8 group_count, 0xC
// group_length; write them only while the block is idle.
module grouped_dequant_embedding_lookup_top #(
	parameter int MAX_ROWS   = gdel_pkg::MAX_ROWS_DEF,
	parameter int MAX_DIM    = gdel_pkg::MAX_DIM_DEF,
	parameter int MAX_GROUPS = gdel_pkg::MAX_GROUPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gdel_cmd_if.sink                      cmd,
	gdel_elem_if.source                   elem,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gdel_pkg::PADDR_W-1:0]  paddr,
	input  logic [gdel_pkg::PDATA_W-1:0]  pwdata,
	output logic [gdel_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int WA = $clog2(MAX_ROWS*MAX_DIM);
	localparam int SA = $clog2(MAX_ROWS*MAX_GROUPS);

	gdel_pkg::cfg_t                 cfg;
	gdel_pkg::meta_t                meta_s1;
	logic                           advance;
	logic                           w_we, s_we, z_we;
	logic [WA-1:0]                  w_waddr, w_raddr;
	logic [SA-1:0]                  g_waddr, g_raddr;
	logic [gdel_pkg::BYTE_W-1:0]    w_byte, z_byte;
	logic [gdel_pkg::SCALE_W-1:0]   scale;

	// configuration registers
	gdel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// command decode and element sequencer
	gdel_seq #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_DIM    (MAX_DIM),
		.MAX_GROUPS (MAX_GROUPS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg),
		.advance (advance),
		.meta_s1 (meta_s1),
		.w_we    (w_we),
		.w_waddr (w_waddr),
		.w_raddr (w_raddr),
		.s_we    (s_we),
		.z_we    (z_we),
		.g_waddr (g_waddr),
		.g_raddr (g_raddr)
	);

	// weight table
	gdel_ram #(
		.WIDTH (gdel_pkg::BYTE_W),
		.DEPTH (MAX_ROWS*MAX_DIM)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (cmd.byte_value),
		.re    (advance),
		.raddr (w_raddr),
		.rdata (w_byte)
	);

	// scale table
	gdel_ram #(
		.WIDTH (gdel_pkg::SCALE_W),
		.DEPTH (MAX_ROWS*MAX_GROUPS)
	) u_scale_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (g_waddr),
		.wdata (unsigned'(cmd.scale_value)),
		.re    (advance),
		.raddr (g_raddr),
		.rdata (scale)
	);

	// zero-point table
	gdel_ram #(
		.WIDTH (gdel_pkg::BYTE_W),
		.DEPTH (MAX_ROWS*MAX_GROUPS)
	) u_zero_ram (
		.clk   (clk),
		.we    (z_we),
		.waddr (g_waddr),
		.wdata (cmd.byte_value),
		.re    (advance),
		.raddr (g_raddr),
		.rdata (z_byte)
	);

	// dequantizer and result register
	gdel_dq u_dq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.meta_s1 (meta_s1),
		.w_byte  (w_byte),
		.z_byte  (z_byte),
		.scale   (scale),
		.advance (advance),
		.elem    (elem)
	);

endmodule
